/* rtl/brf_pkg.sv */
// ----------------------------------------------------------------------------
// brf_pkg
// Shared constants, register map, status codes and control types of the
// bracketing root finder.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int VW = 32;             // point and sample width, Q16.16
  localparam int TW = VW - 1;         // tolerance and half width
  localparam int IW = 16;             // iteration count width
  localparam int PW = 2 * VW;         // product and dividend width
  localparam int CW = $clog2(PW);     // divider step counter
  localparam int AW = 5;              // config address width
  localparam int DW = 32;             // config data width

  // register indexes
  localparam logic [2:0] REG_LOWER = 3'd0;
  localparam logic [2:0] REG_UPPER = 3'd1;
  localparam logic [2:0] REG_TOL   = 3'd2;
  localparam logic [2:0] REG_LIMIT = 3'd3;
  localparam logic [2:0] REG_MODE  = 3'd4;

  // result status codes
  localparam logic [2:0] ST_PROBE         = 3'd0;
  localparam logic [2:0] ST_ZERO          = 3'd1;
  localparam logic [2:0] ST_CONV          = 3'd2;
  localparam logic [2:0] ST_LIMIT         = 3'd3;
  localparam logic [2:0] ST_NOSIGN_ENDS   = 3'd4;
  localparam logic [2:0] ST_NOSIGN_HALVES = 3'd5;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_UPPER = 2'd1,
    PH_PROBE = 2'd2
  } phase_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EVAL   = 8'b0000_0010,
    S_ADV    = 8'b0000_0100,
    S_MUL    = 8'b0000_1000,
    S_DSTART = 8'b0001_0000,
    S_DWAIT  = 8'b0010_0000,
    S_FIN    = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic signed [VW-1:0] lower;
    logic signed [VW-1:0] upper;
    logic [TW-1:0]        tol;
    logic [IW-1:0]        limit;
    logic                 mode;
  } brf_cfg_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic adv;
    logic mul;
    logic div_start;
    logic fin;
  } brf_cmd_t;

  typedef struct packed {
    logic emit_now;
    logic go_adv;
    logic need_div;
    logic div_done;
  } brf_sts_t;

endpackage

/* rtl/bracketing_root_finder.sv */
// ----------------------------------------------------------------------------
// bracketing_root_finder
// Bracketing root search in Q16.16 driven by an outside function evaluator.
// ----------------------------------------------------------------------------
// Send f at the smaller of the two ends with first_sample set; each result is
// the next point to evaluate, or the answer when done_res is set. A result
// that needs no narrowing step (start, exact zero, no sign change) is emitted
// straight after evaluation, a bisection step passes through the advance
// state as well, and a false position step that divides also runs the 64-bit
// serial divider, one quotient bit per clock. A new sample is taken once the
// previous result is in the output register. The user must write
// configuration through the APB-style port only while no search step is in
// flight; the block itself does not enforce it. Tolerance, iteration limit
// and method are used live.
module bracketing_root_finder import brf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AW-1:0]        paddr,
  input  logic [DW-1:0]        pwdata,
  output logic [DW-1:0]        prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [VW-1:0] in_sample_value,
  input  logic                 in_first_sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [VW-1:0] out_probe_point,
  output logic                 out_done_res,
  output logic [2:0]           out_status,
  output logic [IW-1:0]        out_iterations_used,
  output logic [TW-1:0]        out_half_width
);

  brf_cfg_t             cfg_r, cfg_nxt;
  brf_cmd_t             cmd;
  brf_sts_t             sts;
  logic                 cfg_wr, out_free, load_out;
  logic [2:0]           reg_idx;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [VW-1:0] res_probe, probe_r;
  logic                 res_done, done_r;
  logic [2:0]           res_status, status_r;
  logic [IW-1:0]        res_iter, iter_r;
  logic [TW-1:0]        res_half, half_r;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[AW-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_LOWER: cfg_nxt.lower = pwdata;
        REG_UPPER: cfg_nxt.upper = pwdata;
        REG_TOL:   cfg_nxt.tol   = pwdata[TW-1:0];
        REG_LIMIT: cfg_nxt.limit = pwdata[IW-1:0];
        REG_MODE:  cfg_nxt.mode  = pwdata[0];
        default: begin
          // unmapped address
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LOWER: prdata = cfg_r.lower;
      REG_UPPER: prdata = cfg_r.upper;
      REG_TOL:   prdata = DW'(cfg_r.tol);
      REG_LIMIT: prdata = DW'(cfg_r.limit);
      REG_MODE:  prdata = DW'(cfg_r.mode);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lower <= '0;
      cfg_r.upper <= VW'(65536);
      cfg_r.tol   <= TW'(1);
      cfg_r.limit <= IW'(100);
      cfg_r.mode  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  brf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .load_out (load_out),
    .cmd      (cmd),
    .sts      (sts)
  );

  brf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg        (cfg_r),
    .in_sample  (in_sample_value),
    .in_first   (in_first_sample),
    .res_probe  (res_probe),
    .res_done   (res_done),
    .res_status (res_status),
    .res_iter   (res_iter),
    .res_half   (res_half)
  );

  // output register, free when empty or drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      probe_r  <= res_probe;
      done_r   <= res_done;
      status_r <= res_status;
      iter_r   <= res_iter;
      half_r   <= res_half;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_probe_point     = probe_r;
  assign out_done_res        = done_r;
  assign out_status          = status_r;
  assign out_iterations_used = iter_r;
  assign out_half_width      = half_r;

`ifndef NO_ASSERTIONS
  // one sample at a time: a transfer makes the block busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a sample is being processed");

  // final results carry a nonzero status, probes carry none
  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_done_res == (out_status != ST_PROBE)))
    else $error("done flag and status disagree");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_NOSIGN_HALVES))
    else $error("status code out of range");

  // a result is only loaded when the output register has room
  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending result");
`endif

endmodule

/* rtl/brf_div.sv */
// ----------------------------------------------------------------------------
// brf_div
// Restoring unsigned divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
module brf_div import brf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [PW-1:0] dividend,
  input  logic [VW:0]   divisor,
  output logic [PW-1:0] quotient,
  output logic          done
);

  logic [PW-1:0] quo_r, quo_nxt;
  logic [VW:0]   rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VW+1:0] shifted;
  logic [VW+2:0] diff;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[PW-1]};
    diff     = {1'b0, shifted} - {2'b00, divisor};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // borrow clear means the shifted remainder covers the divisor
      if (!diff[VW+2]) begin
        rem_nxt = diff[VW:0];
      end else begin
        rem_nxt = shifted[VW:0];
      end
      quo_nxt = {quo_r[PW-2:0], ~diff[VW+2]};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(PW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

/* rtl/brf_dp.sv */
// ----------------------------------------------------------------------------
// brf_dp
// Bracket registers, sample evaluation, midpoint and false position
// estimate with a registered multiplier and a serial divider.
// ----------------------------------------------------------------------------
module brf_dp import brf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  brf_cmd_t             cmd,
  output brf_sts_t             sts,
  input  brf_cfg_t             cfg,
  input  logic signed [VW-1:0] in_sample,
  input  logic                 in_first,
  output logic signed [VW-1:0] res_probe,
  output logic                 res_done,
  output logic [2:0]           res_status,
  output logic [IW-1:0]        res_iter,
  output logic [TW-1:0]        res_half
);

  logic signed [VW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [VW-1:0] fl_r, fl_nxt, fh_r, fh_nxt;
  logic signed [VW-1:0] lp_r, lp_nxt;
  logic [IW-1:0]        step_r, step_nxt;
  phase_t               phase_r, phase_nxt;
  logic signed [VW-1:0] smp_r;
  logic                 first_r;
  logic [VW-1:0]        w_r, w_nxt, nb_r, nb_nxt;
  logic [VW:0]          nd_r, nd_nxt;
  logic [2:0]           kind_r, kind_nxt;
  logic [PW-1:0]        prod_r, prod_nxt;
  logic signed [VW-1:0] rprobe_r, rprobe_nxt;
  logic                 rdone_r, rdone_nxt;
  logic [2:0]           rstat_r, rstat_nxt;

  logic signed [VW-1:0] lo_ord, hi_ord, mid, est_dir, est_div, est;
  logic [VW-1:0]        w_now, fh_u, qc;
  logic signed [VW:0]   d_now;
  logic [VW:0]          d_u;
  logic                 d_zero, opp, need_div_now, apply;
  logic [2:0]           kind_now, kind;
  logic [PW-1:0]        quotient;
  logic                 div_done;

  // sign product of the two values is positive
  function automatic logic same_sign(input logic signed [VW-1:0] a,
                                     input logic signed [VW-1:0] b);
    return (a != '0) && (b != '0) && (a[VW-1] == b[VW-1]);
  endfunction

  brf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (nd_r),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    lo_ord = (cfg.lower < cfg.upper) ? cfg.lower : cfg.upper;
    hi_ord = (cfg.lower < cfg.upper) ? cfg.upper : cfg.lower;

    w_now  = hi_r - lo_r;
    mid    = lo_r + signed'({1'b0, w_now[VW-1:1]});
    d_now  = {fh_r[VW-1], fh_r} - {fl_r[VW-1], fl_r};
    d_u    = d_now;
    fh_u   = fh_r;
    d_zero = (d_now == '0);
    opp    = (fh_r != '0) && !d_zero && (fh_r[VW-1] != d_now[VW]);
    need_div_now = cfg.mode && !d_zero && !opp;
    est_dir = (!cfg.mode || d_zero) ? mid : hi_r;

    if ({1'b0, w_now} <= {2'b00, cfg.tol}) begin
      kind_now = ST_CONV;
    end else if (step_r >= cfg.limit) begin
      kind_now = ST_LIMIT;
    end else begin
      kind_now = ST_PROBE;
    end

    // clamp the interpolation step to the bracket width
    if (quotient > PW'(w_r)) begin
      qc = w_r;
    end else begin
      qc = quotient[VW-1:0];
    end
    est_div = hi_r - signed'(qc);

    apply = (cmd.adv && !need_div_now) || cmd.fin;
    est   = cmd.fin ? est_div : est_dir;
    kind  = cmd.fin ? kind_r : kind_now;
  end

  always_comb begin
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    fl_nxt     = fl_r;
    fh_nxt     = fh_r;
    lp_nxt     = lp_r;
    step_nxt   = step_r;
    phase_nxt  = phase_r;
    w_nxt      = w_r;
    nb_nxt     = nb_r;
    nd_nxt     = nd_r;
    kind_nxt   = kind_r;
    prod_nxt   = prod_r;
    rprobe_nxt = rprobe_r;
    rdone_nxt  = rdone_r;
    rstat_nxt  = rstat_r;
    sts        = '0;
    sts.div_done = div_done;

    if (cmd.eval) begin
      if (first_r) begin
        lo_nxt     = lo_ord;
        hi_nxt     = hi_ord;
        fl_nxt     = smp_r;
        fh_nxt     = '0;
        step_nxt   = '0;
        lp_nxt     = hi_ord;
        phase_nxt  = PH_UPPER;
        rprobe_nxt = hi_ord;
        rdone_nxt  = 1'b0;
        rstat_nxt  = ST_PROBE;
        sts.emit_now = 1'b1;
      end else begin
        case (phase_r)
          PH_UPPER: begin
            fh_nxt = smp_r;
            if (same_sign(fl_r, smp_r)) begin
              phase_nxt  = PH_IDLE;
              rprobe_nxt = '0;
              rdone_nxt  = 1'b1;
              rstat_nxt  = ST_NOSIGN_ENDS;
              sts.emit_now = 1'b1;
            end else begin
              sts.go_adv = 1'b1;
            end
          end
          PH_PROBE: begin
            step_nxt = step_r + IW'(1);
            if (smp_r == '0) begin
              phase_nxt  = PH_IDLE;
              rprobe_nxt = lp_r;
              rdone_nxt  = 1'b1;
              rstat_nxt  = ST_ZERO;
              sts.emit_now = 1'b1;
            end else if (!same_sign(fl_r, smp_r)) begin
              hi_nxt = lp_r;
              fh_nxt = smp_r;
              sts.go_adv = 1'b1;
            end else if (!same_sign(fh_r, smp_r)) begin
              lo_nxt = lp_r;
              fl_nxt = smp_r;
              sts.go_adv = 1'b1;
            end else begin
              phase_nxt  = PH_IDLE;
              rprobe_nxt = '0;
              rdone_nxt  = 1'b1;
              rstat_nxt  = ST_NOSIGN_HALVES;
              sts.emit_now = 1'b1;
            end
          end
          default: begin
            // idle: a sample without a start is dropped
          end
        endcase
      end
    end

    if (cmd.adv) begin
      sts.need_div = need_div_now;
      w_nxt    = w_now;
      nb_nxt   = fh_u[VW-1] ? (~fh_u + VW'(1)) : fh_u;
      nd_nxt   = d_u[VW] ? (~d_u + (VW+1)'(1)) : d_u;
      kind_nxt = kind_now;
    end

    if (cmd.mul) begin
      prod_nxt = PW'(nb_r) * PW'(w_r);
    end

    if (apply) begin
      rprobe_nxt = est;
      rdone_nxt  = (kind != ST_PROBE);
      rstat_nxt  = kind;
      if (kind == ST_PROBE) begin
        lp_nxt    = est;
        phase_nxt = PH_PROBE;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r    <= '0;
      hi_r    <= '0;
      fl_r    <= '0;
      fh_r    <= '0;
      lp_r    <= '0;
      step_r  <= '0;
      phase_r <= PH_IDLE;
    end else begin
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      fl_r    <= fl_nxt;
      fh_r    <= fh_nxt;
      lp_r    <= lp_nxt;
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r   <= in_sample;
      first_r <= in_first;
    end
    w_r      <= w_nxt;
    nb_r     <= nb_nxt;
    nd_r     <= nd_nxt;
    kind_r   <= kind_nxt;
    prod_r   <= prod_nxt;
    rprobe_r <= rprobe_nxt;
    rdone_r  <= rdone_nxt;
    rstat_r  <= rstat_nxt;
  end

  assign res_probe  = rprobe_r;
  assign res_done   = rdone_r;
  assign res_status = rstat_r;
  assign res_iter   = step_r;
  assign res_half   = w_now[VW-1:1];

endmodule

/* rtl/brf_ctrl.sv */
// ----------------------------------------------------------------------------
// brf_ctrl
// Sequencer of the root finder: takes a sample, steps the datapath through
// evaluation, estimate and division, and hands any result to the output.
// ----------------------------------------------------------------------------
module brf_ctrl import brf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     out_free,
  output logic     load_out,
  output brf_cmd_t cmd,
  input  brf_sts_t sts
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    load_out  = 1'b0;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.emit_now) begin
          state_nxt = S_EMIT;
        end else if (sts.go_adv) begin
          state_nxt = S_ADV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = sts.need_div ? S_MUL : S_EMIT;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // wait for room in the output register
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
